[rtl/assert_macros.svh]
// Assertion macros for the RTL of the NaN run gap filler.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

[rtl/nrgf_pkg.sv]
// Package for the NaN run gap filler: sizes, register codes, queue command types.
// No dependencies; every RTL module imports it.
package nrgf_pkg;

    localparam int RUN_DEPTH  = 63;
    localparam int RUN_CNT_W  = $clog2(RUN_DEPTH + 1);
    localparam int RUN_IDX_W  = $clog2(RUN_DEPTH);
    localparam int WORD_W     = 32;
    localparam int THR_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int OUTST_W    = $clog2(Q_DEPTH + 2);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILL      = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(60);
    localparam logic [WORD_W-1:0] FILL_RESET = 32'h4100_0000;

    localparam logic [WORD_W-1:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [WORD_W-1:0] MANT_MASK = 32'h007F_FFFF;

    typedef enum logic {
        CMD_RAW,
        CMD_FILL
    } t_cmd_kind;

    // One queued job: emit count buffered samples (raw or as fill), then
    // optionally one trailing word; the last item carries scan_end.
    typedef struct packed {
        t_cmd_kind            kind;
        logic [RUN_CNT_W-1:0] count;
        logic                 has_word;
        logic [WORD_W-1:0]    word;
        logic                 scan_end;
    } t_cmd;

    // Run buffer write from the front part.
    typedef struct packed {
        logic                 we;
        logic [RUN_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    data;
    } t_buf_wr;

    function automatic logic is_nan(input logic [WORD_W-1:0] w);
        return ((w & EXP_MASK) == EXP_MASK) && ((w & MANT_MASK) != '0);
    endfunction

endpackage

[rtl/nrgf_cmd_fifo.sv]
// Command queue between the classifying front and the emitting back part.
// Depends on nrgf_pkg for the command type and depth.
module nrgf_cmd_fifo
    import nrgf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/nrgf_front.sv]
// Front part: configuration registers, NaN classification, run tracking.
// Depends on nrgf_pkg; feeds the command queue and the run buffer write port.
module nrgf_front
    import nrgf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WORD_W-1:0]    i_range_word,
    input  logic                 i_scan_end,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output t_buf_wr              o_buf_wr,
    input  logic                 i_raw_done
);

    logic [THR_W-1:0]     r_threshold;
    logic [WORD_W-1:0]    r_fill;
    logic [RUN_CNT_W-1:0] r_pending;
    logic                 r_long;
    logic [OUTST_W-1:0]   r_raw_outst;

    logic [RUN_CNT_W-1:0] n_pending;
    logic                 n_long;
    logic [THR_W-1:0]     eff_thr;
    logic [RUN_CNT_W-1:0] new_cnt;
    logic                 nan;
    logic                 reach;
    logic                 hazard;
    logic                 accept;
    logic                 raw_inc;

    // Clamp threshold to 1..RUN_DEPTH
    always_comb begin
        eff_thr = r_threshold;
        if (eff_thr == '0) begin
            eff_thr = THR_W'(1);
        end
        if (eff_thr > THR_W'(RUN_DEPTH)) begin
            eff_thr = THR_W'(RUN_DEPTH);
        end
    end

    assign nan     = is_nan(i_range_word);
    assign new_cnt = r_pending + 1'b1;
    assign reach   = (new_cnt >= RUN_CNT_W'(eff_thr));
    // Hold a buffered NaN back while a raw flush still reads the buffer
    assign hazard  = nan && !r_long && (r_raw_outst != '0);
    assign o_in_ready = !i_q_full && !hazard;
    assign accept  = i_in_valid && o_in_ready;

    // Classify the transfer and build the queue command
    always_comb begin
        o_push         = 1'b0;
        o_cmd.kind     = CMD_RAW;
        o_cmd.count    = '0;
        o_cmd.has_word = 1'b0;
        o_cmd.word     = r_fill;
        o_cmd.scan_end = i_scan_end;
        o_buf_wr.we    = 1'b0;
        o_buf_wr.addr  = r_pending[RUN_IDX_W-1:0];
        o_buf_wr.data  = i_range_word;
        n_pending      = r_pending;
        n_long         = r_long;
        if (accept) begin
            if (nan) begin
                if (r_long) begin
                    o_push      = 1'b1;
                    o_cmd.kind  = CMD_FILL;
                    o_cmd.count = RUN_CNT_W'(1);
                end else begin
                    o_buf_wr.we = 1'b1;
                    if (reach) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_FILL;
                        o_cmd.count = new_cnt;
                        n_pending   = '0;
                        n_long      = 1'b1;
                    end else if (i_scan_end) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_RAW;
                        o_cmd.count = new_cnt;
                        n_pending   = '0;
                    end else begin
                        n_pending   = new_cnt;
                    end
                end
            end else begin
                o_push         = 1'b1;
                o_cmd.kind     = CMD_RAW;
                o_cmd.count    = r_pending;
                o_cmd.has_word = 1'b1;
                o_cmd.word     = i_range_word;
                n_pending      = '0;
                n_long         = 1'b0;
            end
            if (i_scan_end) begin
                n_pending = '0;
                n_long    = 1'b0;
            end
        end
    end

    assign raw_inc = o_push && (o_cmd.kind == CMD_RAW) && (o_cmd.count != '0);

    // Hold configuration and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_fill      <= FILL_RESET;
            r_pending   <= '0;
            r_long      <= 1'b0;
            r_raw_outst <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    CFG_FILL:      r_fill      <= i_cfg_data;
                    default:       ;
                endcase
            end
            r_pending   <= n_pending;
            r_long      <= n_long;
            r_raw_outst <= r_raw_outst + OUTST_W'(raw_inc) - OUTST_W'(i_raw_done);
        end
    end

endmodule

[rtl/nrgf_back.sv]
// Back part: run buffer memory and the sequencer that emits queued jobs.
// Depends on nrgf_pkg and assert_macros.svh; drives the output register.
`include "assert_macros.svh"
module nrgf_back
    import nrgf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_buf_wr           i_buf_wr,
    input  t_cmd              i_cmd,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_raw_done,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_out_word,
    output logic              o_out_scan_end
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [RUN_CNT_W-1:0] r_idx;
    logic [WORD_W-1:0]    r_rd_data;
    logic [WORD_W-1:0]    r_mem [RUN_DEPTH];
    logic                 r_o_valid;
    logic [WORD_W-1:0]    r_o_word;
    logic                 r_o_end;

    logic in_buf;
    logic last;
    logic out_free;
    logic load;
    logic busy;

    assign in_buf   = (r_idx < r_cmd.count);
    assign last     = in_buf ? ((r_idx == r_cmd.count - 1'b1) && !r_cmd.has_word) : 1'b1;
    assign out_free = !r_o_valid || i_out_ready;
    assign load     = (r_state == S_LOAD) && out_free;
    assign busy     = (r_state != S_IDLE);
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_raw_done = load && last && (r_cmd.kind == CMD_RAW) && (r_cmd.count != '0);

    assign o_out_valid    = r_o_valid;
    assign o_out_word     = r_o_word;
    assign o_out_scan_end = r_o_end;

    // Write held NaN samples into the run buffer
    always_ff @(posedge i_clk) begin
        if (i_buf_wr.we) begin
            r_mem[i_buf_wr.addr] <= i_buf_wr.data;
        end
    end

    // Sequence one job: fetch each element, then load it into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // Set valid on a load, drop it once the transfer completes
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (in_buf) begin
                        r_rd_data <= r_mem[r_idx[RUN_IDX_W-1:0]];
                    end
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_o_word  <= (in_buf && (r_cmd.kind == CMD_RAW)) ? r_rd_data
                                                                         : r_cmd.word;
                        r_o_end   <= r_cmd.scan_end && last;
                        r_idx     <= r_idx + 1'b1;
                        r_state   <= last ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_idx_bound, busy |-> (r_idx <= r_cmd.count), "index past job length")
    `ASSERT_CLK(a_done_raw, o_raw_done |-> (r_cmd.kind == CMD_RAW), "raw done on fill job")
    `ASSERT_CLK(a_pop_start, o_pop |=> (r_state == S_READ), "pop without job start")
    `ASSERT_NEVER(a_fill_word, busy && (r_cmd.kind == CMD_FILL) && r_cmd.has_word, "fill with word")

endmodule

[rtl/nan_run_gap_filler_top.sv]
// Top level of the NaN run gap filler: front, command queue, back.
// Depends on nrgf_pkg, nrgf_front, nrgf_cmd_fifo and nrgf_back.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-----------------------------------
//  cfg     | in        | i_cfg_we                     | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready      | i_range_word, i_scan_end
//  out     | out       | o_out_valid / i_out_ready    | o_out_out_word, o_out_out_scan_end
//
// The front takes one input transfer per cycle while the command queue has room and no NaN is held back.
// The back takes each queued job while idle, then emits each output item as a buffer read
// followed by an output load, which waits until the output register is free.
// A NaN that would enter the run buffer stalls while a raw flush still reads it.
// Reset is synchronous, active low; it restores the register defaults and empties
// the queue. The run buffer needs no clearing.
module nan_run_gap_filler_top
    import nrgf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WORD_W-1:0]    i_range_word,
    input  logic                 i_scan_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_out_out_word,
    output logic                 o_out_out_scan_end
);

    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_buf_wr buf_wr;
    logic    push;
    logic    pop;
    logic    q_empty;
    logic    q_full;
    logic    raw_done;

    // Classify input transfers
    nrgf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_range_word (i_range_word),
        .i_scan_end   (i_scan_end),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_buf_wr     (buf_wr),
        .i_raw_done   (raw_done)
    );

    // Decouple front and back
    nrgf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Emit jobs in order
    nrgf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_buf_wr       (buf_wr),
        .i_cmd          (head_cmd),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_raw_done     (raw_done),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_out_word),
        .o_out_scan_end (o_out_out_scan_end)
    );

endmodule
